// ===== src/stse_pkg.sv =====
// Shared types and constants for the sorted table search engine.
// No dependencies.
package stse_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int DATA_W      = 32;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [DATA_W-1:0] data_t;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_LINEAR = 2'd1,
        KIND_BINARY = 2'd2,
        KIND_UNUSED = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_FOUND     = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_LOADED    = 2'd2,
        STATUS_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LIN,
        ST_INS,
        ST_INS_LAST,
        ST_BIN_ISSUE,
        ST_BIN_CMP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic  load_we;
        idx_t  load_waddr;
        data_t load_wdata;
        idx_t  load_raddr;
        logic  sorted_we;
        idx_t  sorted_waddr;
        data_t sorted_wdata;
        idx_t  sorted_raddr;
    } mem_req_t;

    typedef struct packed {
        data_t load_rdata;
        data_t sorted_rdata;
    } mem_rsp_t;

    typedef struct packed {
        logic eq;
        logic gt;
    } cmp_res_t;

endpackage

// ===== src/stse_store.sv =====
// Load-order and sorted tables, one write and one registered read port each.
// Depends on stse_pkg.
module stse_store (
    input  logic              clk,
    input  stse_pkg::mem_req_t req,
    output stse_pkg::mem_rsp_t rsp
);

    stse_pkg::data_t load_mem_reg   [stse_pkg::TABLE_DEPTH];
    stse_pkg::data_t sorted_mem_reg [stse_pkg::TABLE_DEPTH];
    stse_pkg::data_t load_rdata_reg;
    stse_pkg::data_t sorted_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.load_we)
        begin
            load_mem_reg[req.load_waddr] <= req.load_wdata;
        end
        load_rdata_reg <= load_mem_reg[req.load_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (req.sorted_we)
        begin
            sorted_mem_reg[req.sorted_waddr] <= req.sorted_wdata;
        end
        sorted_rdata_reg <= sorted_mem_reg[req.sorted_raddr];
    end

    assign rsp.load_rdata   = load_rdata_reg;
    assign rsp.sorted_rdata = sorted_rdata_reg;

endmodule

// ===== src/stse_cmp.sv =====
// Shared signed compare unit: table word against the search key.
// Depends on stse_pkg.
module stse_cmp (
    input  stse_pkg::data_t    entry,
    input  stse_pkg::data_t    key,
    output stse_pkg::cmp_res_t res
);

    assign res.eq = (entry == key);
    assign res.gt = ($signed(entry) > $signed(key));

endmodule

// ===== src/sorted_table_search_engine_top.sv =====
// Sorted table search engine: sequencer around stse_store and one shared stse_cmp.
// A load shifts larger sorted entries up one place (none if the table is empty or full),
// a linear search compares entries in load order, a binary search issues and compares probes.
// One beat in flight: in_ready rises with out_valid, so a new beat is taken only once the result is registered;
// a stalled result beat holds the engine until it is taken.
// Reset clears element count and control; table contents stay undefined (no clear pass).
module sorted_table_search_engine_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  kind,
    input  logic signed [31:0]          value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  status,
    output logic [5:0]                  position
);

    stse_pkg::state_t   state_reg, state_next;
    stse_pkg::cnt_t     count_reg, count_next;
    stse_pkg::idx_t     idx_reg, idx_next;
    stse_pkg::cnt_t     first_reg, first_next;
    stse_pkg::cnt_t     hi_reg, hi_next;
    stse_pkg::idx_t     mid_reg, mid_next;
    stse_pkg::data_t    key_reg, key_next;
    stse_pkg::status_t  res_status_reg, res_status_next;
    stse_pkg::idx_t     res_pos_reg, res_pos_next;
    logic               out_valid_reg, out_valid_next;
    stse_pkg::status_t  out_status_reg, out_status_next;
    stse_pkg::idx_t     out_pos_reg, out_pos_next;

    stse_pkg::mem_req_t mem_req;
    stse_pkg::mem_rsp_t mem_rsp;
    stse_pkg::data_t    cmp_entry;
    stse_pkg::cmp_res_t cmp_res;

    logic               in_beat;
    logic               out_free;
    logic               is_full;
    logic               lin_last;
    logic               bin_empty;
    logic [stse_pkg::CNT_W:0] mid_sum;
    stse_pkg::idx_t     mid_calc;

    stse_store u_store (
        .clk (clk),
        .req (mem_req),
        .rsp (mem_rsp)
    );

    assign cmp_entry = (state_reg == stse_pkg::ST_LIN) ? mem_rsp.load_rdata
                                                       : mem_rsp.sorted_rdata;

    stse_cmp u_cmp (
        .entry (cmp_entry),
        .key   (key_reg),
        .res   (cmp_res)
    );

    assign in_ready  = (state_reg == stse_pkg::ST_IDLE);
    assign in_beat   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign is_full   = (count_reg == stse_pkg::CNT_W'(stse_pkg::TABLE_DEPTH));
    assign lin_last  = ((stse_pkg::CNT_W'(idx_reg) + stse_pkg::CNT_W'(1)) == count_reg);
    assign bin_empty = (first_reg >= hi_reg);
    assign mid_sum   = {1'b0, first_reg} + {1'b0, hi_reg} - (stse_pkg::CNT_W+1)'(1);
    assign mid_calc  = mid_sum[stse_pkg::IDX_W:1];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            stse_pkg::ST_IDLE:
            begin
                if (in_beat)
                begin
                    case (stse_pkg::kind_t'(kind))
                        stse_pkg::KIND_LOAD:
                            state_next = (is_full || count_reg == '0) ?
                                         stse_pkg::ST_FINISH : stse_pkg::ST_INS;
                        stse_pkg::KIND_LINEAR:
                            state_next = (count_reg == '0) ?
                                         stse_pkg::ST_FINISH : stse_pkg::ST_LIN;
                        stse_pkg::KIND_BINARY:
                            state_next = stse_pkg::ST_BIN_ISSUE;
                        default:
                            state_next = stse_pkg::ST_FINISH;
                    endcase
                end
            end
            stse_pkg::ST_LIN:
            begin
                if (cmp_res.eq || lin_last)
                begin
                    state_next = stse_pkg::ST_FINISH;
                end
            end
            stse_pkg::ST_INS:
            begin
                if (!cmp_res.gt)
                begin
                    state_next = stse_pkg::ST_FINISH;
                end
                else if (idx_reg == stse_pkg::IDX_W'(1))
                begin
                    state_next = stse_pkg::ST_INS_LAST;
                end
            end
            stse_pkg::ST_INS_LAST:
                state_next = stse_pkg::ST_FINISH;
            stse_pkg::ST_BIN_ISSUE:
                state_next = bin_empty ? stse_pkg::ST_FINISH : stse_pkg::ST_BIN_CMP;
            stse_pkg::ST_BIN_CMP:
                state_next = cmp_res.eq ? stse_pkg::ST_FINISH : stse_pkg::ST_BIN_ISSUE;
            stse_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = stse_pkg::ST_IDLE;
                end
            end
            default:
                state_next = stse_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        count_next      = count_reg;
        idx_next        = idx_reg;
        first_next      = first_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;

        mem_req.load_we      = 1'b0;
        mem_req.load_waddr   = count_reg[stse_pkg::IDX_W-1:0];
        mem_req.load_wdata   = value;
        mem_req.load_raddr   = '0;
        mem_req.sorted_we    = 1'b0;
        mem_req.sorted_waddr = idx_reg;
        mem_req.sorted_wdata = key_reg;
        mem_req.sorted_raddr = stse_pkg::IDX_W'(count_reg - stse_pkg::CNT_W'(1));

        case (state_reg)
            stse_pkg::ST_IDLE:
            begin
                if (in_beat)
                begin
                    key_next        = value;
                    res_status_next = stse_pkg::STATUS_NOT_FOUND;
                    res_pos_next    = '0;
                    idx_next        = '0;
                    first_next      = '0;
                    hi_next         = count_reg;
                    case (stse_pkg::kind_t'(kind))
                        stse_pkg::KIND_LOAD:
                        begin
                            if (is_full)
                            begin
                                res_status_next = stse_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                mem_req.load_we = 1'b1;
                                res_status_next = stse_pkg::STATUS_LOADED;
                                res_pos_next    = count_reg[stse_pkg::IDX_W-1:0];
                                idx_next        = count_reg[stse_pkg::IDX_W-1:0];
                                if (count_reg == '0)
                                begin
                                    mem_req.sorted_we    = 1'b1;
                                    mem_req.sorted_waddr = '0;
                                    mem_req.sorted_wdata = value;
                                    count_next           = count_reg + stse_pkg::CNT_W'(1);
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            stse_pkg::ST_LIN:
            begin
                mem_req.load_raddr = idx_reg + stse_pkg::IDX_W'(1);
                idx_next           = idx_reg + stse_pkg::IDX_W'(1);
                if (cmp_res.eq)
                begin
                    res_status_next = stse_pkg::STATUS_FOUND;
                    res_pos_next    = idx_reg;
                end
            end
            stse_pkg::ST_INS:
            begin
                mem_req.sorted_we    = 1'b1;
                mem_req.sorted_waddr = idx_reg;
                mem_req.sorted_raddr = idx_reg - stse_pkg::IDX_W'(2);
                if (cmp_res.gt)
                begin
                    mem_req.sorted_wdata = mem_rsp.sorted_rdata;
                    idx_next             = idx_reg - stse_pkg::IDX_W'(1);
                end
                else
                begin
                    count_next = count_reg + stse_pkg::CNT_W'(1);
                end
            end
            stse_pkg::ST_INS_LAST:
            begin
                mem_req.sorted_we    = 1'b1;
                mem_req.sorted_waddr = '0;
                count_next           = count_reg + stse_pkg::CNT_W'(1);
            end
            stse_pkg::ST_BIN_ISSUE:
            begin
                mem_req.sorted_raddr = mid_calc;
                mid_next             = mid_calc;
            end
            stse_pkg::ST_BIN_CMP:
            begin
                if (cmp_res.eq)
                begin
                    res_status_next = stse_pkg::STATUS_FOUND;
                    res_pos_next    = mid_reg;
                end
                else if (cmp_res.gt)
                begin
                    hi_next = stse_pkg::CNT_W'(mid_reg);
                end
                else
                begin
                    first_next = stse_pkg::CNT_W'(mid_reg) + stse_pkg::CNT_W'(1);
                end
            end
            stse_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_pos_next    = res_pos_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stse_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        first_reg      <= first_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        out_status_reg <= out_status_next;
        out_pos_reg    <= out_pos_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign position  = out_pos_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= stse_pkg::CNT_W'(stse_pkg::TABLE_DEPTH))
        else $error("element count above table depth");

    a_lin_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == stse_pkg::ST_LIN) |-> (stse_pkg::CNT_W'(idx_reg) < count_reg))
        else $error("linear scan past loaded entries");

    a_mid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == stse_pkg::ST_BIN_CMP) |->
        (stse_pkg::CNT_W'(mid_reg) >= first_reg && stse_pkg::CNT_W'(mid_reg) < hi_reg))
        else $error("binary probe outside search range");

    a_loaded_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == stse_pkg::ST_FINISH && res_status_reg == stse_pkg::STATUS_LOADED) |->
        (res_pos_reg == stse_pkg::IDX_W'(count_reg - stse_pkg::CNT_W'(1))))
        else $error("loaded position does not match count");

    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == stse_pkg::ST_FINISH))
        else $error("result beat raised outside finish");

endmodule

// ===== sim/search_checker.sv =====
`timescale 1ns / 100ps
// Checker for the sorted table search engine: watches both channels, predicts each result
// from a private copy of both tables and compares field by field. Depends on stse_pkg.
module search_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         kind,
    input  logic signed [31:0] value,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [1:0]         status,
    input  logic [5:0]         position,
    output int unsigned        fail_count,
    output int unsigned        pending_count
);

    typedef struct packed {
        stse_pkg::status_t st;
        stse_pkg::idx_t    pos;
    } search_result_t;

    logic signed [stse_pkg::DATA_W-1:0] load_order_copy [stse_pkg::TABLE_DEPTH];
    logic signed [stse_pkg::DATA_W-1:0] sorted_copy     [stse_pkg::TABLE_DEPTH];
    int unsigned              entry_count;
    search_result_t           expected_results [$];
    int unsigned              fails;

    initial
    begin
        entry_count   = 0;
        fails         = 0;
    end

    function automatic search_result_t predict_search_result(input stse_pkg::kind_t k,
                                                             input logic signed [31:0] v);
        search_result_t res;
        int             p;
        int             first;
        int             last;
        int             mid;
        bit             done;
        res.st  = stse_pkg::STATUS_NOT_FOUND;
        res.pos = '0;
        done    = 0;
        case (k)
            stse_pkg::KIND_LOAD:
            begin
                if (entry_count >= stse_pkg::TABLE_DEPTH)
                begin
                    res.st = stse_pkg::STATUS_FULL;
                end
                else
                begin
                    load_order_copy[entry_count] = v;
                    p = entry_count;
                    while (p > 0 && !done)
                    begin
                        if (sorted_copy[p-1] > v)
                        begin
                            sorted_copy[p] = sorted_copy[p-1];
                            p--;
                        end
                        else
                            done = 1;
                    end
                    sorted_copy[p] = v;
                    res.st  = stse_pkg::STATUS_LOADED;
                    res.pos = stse_pkg::idx_t'(entry_count);
                    entry_count++;
                end
            end
            stse_pkg::KIND_LINEAR:
            begin
                for (int i = 0; i < int'(entry_count); i++)
                begin
                    if (!done && load_order_copy[i] == v)
                    begin
                        res.st  = stse_pkg::STATUS_FOUND;
                        res.pos = stse_pkg::idx_t'(i);
                        done    = 1;
                    end
                end
            end
            stse_pkg::KIND_BINARY:
            begin
                first = 0;
                last  = int'(entry_count) - 1;
                while (first <= last && !done)
                begin
                    mid = (first + last) / 2;
                    if (v == sorted_copy[mid])
                    begin
                        res.st  = stse_pkg::STATUS_FOUND;
                        res.pos = stse_pkg::idx_t'(mid);
                        done    = 1;
                    end
                    else if (v < sorted_copy[mid])
                        last = mid - 1;
                    else
                        first = mid + 1;
                end
            end
            default:
            begin
                res.st = stse_pkg::STATUS_NOT_FOUND;
            end
        endcase
        return res;
    endfunction

    always @(posedge clk)
    begin
        search_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    if (fails < 10)
                        $display("unexpected result beat: status %0d position %0d",
                                 status, position);
                    fails++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.st || position !== want.pos)
                    begin
                        if (fails < 10)
                            $display({"mismatch: expected status %0d position %0d, ",
                                      "got status %0d position %0d"},
                                     want.st, want.pos, status, position);
                        fails++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(
                    predict_search_result(stse_pkg::kind_t'(kind), value));
        end
        fail_count    <= fails;
        pending_count <= $unsigned(expected_results.size());
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Top of the sorted table search engine testbench: clock, reset, stimulus and verdict.
// Depends on stse_pkg, sorted_table_search_engine_top and search_checker.
module testbench;

    localparam int RANDOM_ITEMS = 1500;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         kind;
    logic signed [31:0] value;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         status;
    logic [5:0]         position;
    logic               steady;
    int unsigned        fail_count;
    int unsigned        pending_count;

    logic signed [31:0] loaded_vals [$];
    int unsigned        fill;

    sorted_table_search_engine_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .position  (position)
    );

    search_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .position      (position),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
        out_ready <= steady || ($urandom_range(0, 99) >= 13);

    initial
    begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_beat(input stse_pkg::kind_t k, input logic signed [31:0] v);
        while (!steady && $urandom_range(0, 99) < 13)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        value    <= v;
        do
            @(posedge clk);
        while (!in_ready);
        if (k == stse_pkg::KIND_LOAD && fill < stse_pkg::TABLE_DEPTH)
        begin
            loaded_vals.push_back(v);
            fill++;
        end
    endtask

    function automatic logic signed [31:0] pick_value(input int hit_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < hit_pct && loaded_vals.size() != 0)
            return loaded_vals[$urandom_range(0, loaded_vals.size() - 1)];
        else if (r < hit_pct + 10)
        begin
            case ($urandom_range(0, 3))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        else if (r < hit_pct + 25)
            return $signed($urandom_range(0, 16)) - 32'sd8;
        return $signed($urandom);
    endfunction

    initial
    begin
        int r;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        kind      = stse_pkg::KIND_LOAD;
        value     = '0;
        steady    = 1'b0;
        fill      = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table and unused kind
        send_beat(stse_pkg::KIND_LINEAR, 32'sd0);
        send_beat(stse_pkg::KIND_BINARY, 32'sd0);
        send_beat(stse_pkg::KIND_UNUSED, 32'sh7fff_ffff);
        // extremes and equal values
        send_beat(stse_pkg::KIND_LOAD, 32'sh8000_0000);
        send_beat(stse_pkg::KIND_LOAD, 32'sh7fff_ffff);
        send_beat(stse_pkg::KIND_LOAD, 32'sd0);
        send_beat(stse_pkg::KIND_LOAD, -32'sd1);
        send_beat(stse_pkg::KIND_LOAD, 32'sd5);
        send_beat(stse_pkg::KIND_LOAD, 32'sd5);
        send_beat(stse_pkg::KIND_LOAD, -32'sd7);
        send_beat(stse_pkg::KIND_LOAD, 32'sd5);
        send_beat(stse_pkg::KIND_LINEAR, 32'sh8000_0000);
        send_beat(stse_pkg::KIND_LINEAR, 32'sh7fff_ffff);
        send_beat(stse_pkg::KIND_LINEAR, 32'sd5);
        send_beat(stse_pkg::KIND_LINEAR, 32'sd12345);
        send_beat(stse_pkg::KIND_BINARY, 32'sh8000_0000);
        send_beat(stse_pkg::KIND_BINARY, 32'sh7fff_ffff);
        send_beat(stse_pkg::KIND_BINARY, 32'sd5);
        send_beat(stse_pkg::KIND_BINARY, -32'sd7);
        send_beat(stse_pkg::KIND_BINARY, 32'sd1);
        send_beat(stse_pkg::KIND_BINARY, -32'sd1);
        send_beat(stse_pkg::KIND_UNUSED, 32'sh8000_0000);

        // loads are rare so that queries see every fill level
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady <= (n >= 500 && n < 800);
            r = $urandom_range(0, 99);
            if (r < 6)
                send_beat(stse_pkg::KIND_LOAD, pick_value(20));
            else if (r < 50)
                send_beat(stse_pkg::KIND_LINEAR, pick_value(45));
            else if (r < 96)
                send_beat(stse_pkg::KIND_BINARY, pick_value(45));
            else
                send_beat(stse_pkg::KIND_UNUSED, pick_value(10));
        end

        // fill up, then refused loads on a full table
        while (fill < stse_pkg::TABLE_DEPTH)
            send_beat(stse_pkg::KIND_LOAD, pick_value(20));
        for (int n = 0; n < 3; n++)
            send_beat(stse_pkg::KIND_LOAD, pick_value(20));
        for (int n = 0; n < 20; n++)
            send_beat(n[0] ? stse_pkg::KIND_BINARY : stse_pkg::KIND_LINEAR, pick_value(60));
        in_valid <= 1'b0;
        steady   <= 1'b0;

        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
src/stse_pkg.sv
src/stse_store.sv
src/stse_cmp.sv
src/sorted_table_search_engine_top.sv
sim/search_checker.sv
sim/testbench.sv
